@@ sv/rmsd_pkg.sv @@
// Package for the running mean and standard deviation block.
// Holds the shared widths, the sequencer state type and the divider request struct.
// Depends on nothing.
package rmsd_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int COUNT_BITS  = 24;
	localparam int FRAC_BITS   = 16;
	localparam int MEAN_BITS   = SAMPLE_BITS + FRAC_BITS;
	localparam int SUMSQ_BITS  = 64;
	localparam int ROOT_BITS   = SUMSQ_BITS / 2;
	localparam int DIV_CNT_BITS  = $clog2(SUMSQ_BITS + 1);
	localparam int SQRT_CNT_BITS = $clog2(ROOT_BITS + 1);
	localparam int OUT_BITS    = 176;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	localparam logic ACC_TOTAL  = 1'b0;
	localparam logic ACC_REGION = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_DIVQ,
		ST_MUL,
		ST_VSTART,
		ST_DIVV,
		ST_SQRT,
		ST_NEXT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                  start;
		logic [SUMSQ_BITS-1:0] dividend;
		logic [COUNT_BITS-1:0] divisor;
	} div_req_t;

endpackage

@@ sv/running_mean_stddev.sv @@
// Top level of the running mean and standard deviation block.
// Uses rmsd_pkg, rmsd_div and rmsd_sqrt.

// Each request carries a sample and two clear flags; the block updates a total and a
// region Welford accumulator in turn and returns one result with mean, sample standard
// deviation and count of both. The block works on one item at a time, from one request
// to the next. Each accumulator passes through a start state, a divide for the mean step,
// a state to add the product, a state to start the variance divide, a divide for the
// variance, a square root and a state to move on. An accumulator that restarts with this
// sample goes from its start state straight to the move-on state. The block also passes
// through the idle state that takes the request and the state that loads the result.
// s_tready is high only while idle; a finished result waits in the output register
// while the next request is taken, and a result that is still unread holds the
// block in its final state.
module running_mean_stddev (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [15:0]  s_tdata,  // sample
	input  logic [1:0]   s_tuser,  // new_region, new_total
	output logic         m_tvalid,
	input  logic         m_tready,
	// region_mean, region_sd, region_count, total_mean, total_sd, total_count
	output logic [175:0] m_tdata
);
	import rmsd_pkg::*;

	state_t state_q, state_d;

	logic [MEAN_BITS-1:0]  xq_q;
	logic                  acc_q;
	logic [MEAN_BITS-1:0]  avg_q   [2];
	logic [SUMSQ_BITS-1:0] sumsq_q [2];
	logic [COUNT_BITS-1:0] num_q   [2];
	logic                  empty_q [2];
	logic [ROOT_BITS-1:0]  sd_q    [2];
	logic [MEAN_BITS-1:0]  mag_q;
	logic                  up_q;
	logic [SUMSQ_BITS-1:0] prod_s1;
	logic                  m_tvalid_q;
	logic [OUT_BITS-1:0]   m_tdata_q;

	div_req_t                div_req;
	logic                    div_done;
	logic [SUMSQ_BITS-1:0]   div_quot;
	logic                    sqrt_start;
	logic                    sqrt_done;
	logic [ROOT_BITS-1:0]    sqrt_root;

	logic                    accept;
	logic                    load_out;
	logic [COUNT_BITS-1:0]   num_inc;
	logic [MEAN_BITS-1:0]    avg_cur;
	logic                    up_cur;
	logic [MEAN_BITS-1:0]    mag_cur;
	logic [MEAN_BITS-1:0]    q_cur;
	logic [SUMSQ_BITS:0]     sum_wide;

	assign accept   = s_tvalid && s_tready;
	assign avg_cur  = avg_q[acc_q];
	assign num_inc  = (num_q[acc_q] == COUNT_MAX) ? num_q[acc_q] : num_q[acc_q] + 1'b1;
	assign up_cur   = xq_q >= avg_cur;
	assign mag_cur  = up_cur ? xq_q - avg_cur : avg_cur - xq_q;
	assign q_cur    = div_quot[MEAN_BITS-1:0];
	assign sum_wide = {1'b0, sumsq_q[acc_q]} + {1'b0, prod_s1};

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (s_tvalid) state_d = ST_START;
			ST_START:  state_d = empty_q[acc_q] ? ST_NEXT : ST_DIVQ;
			ST_DIVQ:   if (div_done) state_d = ST_MUL;
			ST_MUL:    state_d = ST_VSTART;
			ST_VSTART: state_d = ST_DIVV;
			ST_DIVV:   if (div_done) state_d = ST_SQRT;
			ST_SQRT:   if (sqrt_done) state_d = ST_NEXT;
			ST_NEXT:   state_d = (acc_q == ACC_REGION) ? ST_DONE : ST_START;
			ST_DONE:   if (!m_tvalid_q || m_tready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready         = 1'b0;
		load_out         = 1'b0;
		sqrt_start       = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = {{(SUMSQ_BITS-MEAN_BITS){1'b0}}, mag_cur};
		div_req.divisor  = num_inc;
		case (state_q)
			ST_IDLE:   s_tready = 1'b1;
			ST_START:  div_req.start = !empty_q[acc_q];
			ST_VSTART: begin
				div_req.start    = 1'b1;
				div_req.dividend = sumsq_q[acc_q];
				div_req.divisor  = num_q[acc_q] - 1'b1;
			end
			ST_DIVV:   sqrt_start = div_done;
			ST_DONE:   load_out = !m_tvalid_q || m_tready;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			acc_q      <= ACC_TOTAL;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < 2; i++) begin
				avg_q[i]   <= '0;
				sumsq_q[i] <= '0;
				num_q[i]   <= '0;
				empty_q[i] <= 1'b1;
				sd_q[i]    <= '0;
			end
		end else begin
			state_q <= state_d;
			if (load_out)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (accept) begin
					acc_q <= ACC_TOTAL;
					if (s_tuser[1]) empty_q[ACC_TOTAL]  <= 1'b1;
					if (s_tuser[0]) empty_q[ACC_REGION] <= 1'b1;
				end
				ST_START: begin
					if (empty_q[acc_q]) begin
						avg_q[acc_q]   <= xq_q;
						sumsq_q[acc_q] <= '0;
						num_q[acc_q]   <= COUNT_BITS'(1);
						empty_q[acc_q] <= 1'b0;
						sd_q[acc_q]    <= '0;
					end else begin
						num_q[acc_q] <= num_inc;
					end
				end
				ST_DIVQ: if (div_done)
					avg_q[acc_q] <= up_q ? avg_cur + q_cur : avg_cur - q_cur;
				ST_MUL:
					sumsq_q[acc_q] <= sum_wide[SUMSQ_BITS] ? {SUMSQ_BITS{1'b1}}
					                                       : sum_wide[SUMSQ_BITS-1:0];
				ST_SQRT: if (sqrt_done) sd_q[acc_q] <= sqrt_root;
				ST_NEXT: acc_q <= ACC_REGION;
				default: ;
			endcase
		end
	end

	// Payload registers: sample, mean difference, product and result.
	always_ff @(posedge clk) begin
		if (accept)
			xq_q <= {s_tdata[SAMPLE_BITS-1:0], {FRAC_BITS{1'b0}}};
		if (state_q == ST_START) begin
			mag_q <= mag_cur;
			up_q  <= up_cur;
		end
		// The new mean lies between the old mean and the sample, so the product is exact.
		if (state_q == ST_DIVQ && div_done)
			prod_s1 <= mag_q * (mag_q - q_cur);
		if (load_out)
			m_tdata_q <= {num_q[ACC_TOTAL], sd_q[ACC_TOTAL], avg_q[ACC_TOTAL],
			              num_q[ACC_REGION], sd_q[ACC_REGION], avg_q[ACC_REGION]};
	end

	rmsd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quot     (div_quot)
	);

	rmsd_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (div_quot),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

@@ sv/rmsd_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Used for the mean step and for the variance of both accumulators; uses rmsd_pkg.
module rmsd_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rmsd_pkg::div_req_t             req,
	output logic                           done,
	output logic [rmsd_pkg::SUMSQ_BITS-1:0] quot
);
	import rmsd_pkg::*;

	logic [COUNT_BITS-1:0]   rem_q;
	logic [COUNT_BITS-1:0]   dsr_q;
	logic [SUMSQ_BITS-1:0]   quo_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic                    done_q;
	logic [COUNT_BITS:0]     trial;
	logic                    fits;

	assign trial = {rem_q, quo_q[SUMSQ_BITS-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= DIV_CNT_BITS'(SUMSQ_BITS);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == DIV_CNT_BITS'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dsr_q <= req.divisor;
			quo_q <= req.dividend;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? COUNT_BITS'(trial - {1'b0, dsr_q}) : trial[COUNT_BITS-1:0];
			quo_q <= {quo_q[SUMSQ_BITS-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

@@ sv/rmsd_sqrt.sv @@
// Integer square root by digit recurrence, one root bit per cycle.
// Returns floor(sqrt(radicand)); uses rmsd_pkg.
module rmsd_sqrt (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [rmsd_pkg::SUMSQ_BITS-1:0] radicand,
	output logic                            done,
	output logic [rmsd_pkg::ROOT_BITS-1:0]  root
);
	import rmsd_pkg::*;

	logic [SUMSQ_BITS-1:0]    rad_q;
	logic [ROOT_BITS+1:0]     rem_q;
	logic [ROOT_BITS-1:0]     root_q;
	logic [SQRT_CNT_BITS-1:0] cnt_q;
	logic                     done_q;
	logic [ROOT_BITS+3:0]     trial;
	logic [ROOT_BITS+3:0]     sub;
	logic                     fits;

	assign trial = {rem_q, rad_q[SUMSQ_BITS-1:SUMSQ_BITS-2]};
	assign sub   = {2'b00, root_q, 2'b01};
	assign fits  = trial >= sub;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= SQRT_CNT_BITS'(ROOT_BITS);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == SQRT_CNT_BITS'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			rad_q  <= {rad_q[SUMSQ_BITS-3:0], 2'b00};
			// The remainder stays below twice the root plus one, so the top bits drop.
			rem_q  <= fits ? (ROOT_BITS+2)'(trial - sub) : trial[ROOT_BITS+1:0];
			root_q <= {root_q[ROOT_BITS-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

@@ sv/rmsd_checker.sv @@
// Port-level checks for the running mean and standard deviation block.
// Bound to running_mean_stddev; depends on nothing else.
module rmsd_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [175:0] m_tdata
);

	// Each request is worked on alone, so ready drops straight after one is taken.
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while the previous one is still in work");

	// Every result counts at least the sample just added.
	a_counts_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[87:64] != 24'd0) && (m_tdata[175:152] != 24'd0))
		else $error("result with a zero count");

	// A new result never appears in the cycle straight after a request is taken.
	a_no_result_while_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !(m_tvalid && $rose(m_tvalid)))
		else $error("result appeared in the cycle after a request");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule

bind running_mean_stddev rmsd_checker u_rmsd_checker (.*);

@@ tb/sv/tb_running_mean_stddev.sv @@
`timescale 1ns / 1ps
// Testbench for running_mean_stddev: drives sample requests and checks every result
// against a Welford predictor kept alongside. Depends on rmsd_pkg and running_mean_stddev.
module tb_running_mean_stddev;
	import rmsd_pkg::*;

	typedef struct {
		logic [63:0] avg;
		logic [63:0] sumsq;
		logic [63:0] num;
		bit          empty;
	} welford_t;

	typedef struct packed {
		logic [23:0] total_count;
		logic [31:0] total_sd;
		logic [31:0] total_mean;
		logic [23:0] region_count;
		logic [31:0] region_sd;
		logic [31:0] region_mean;
	} stats_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [15:0]  s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [175:0] m_tdata;

	welford_t region_acc, total_acc;
	stats_t   expected_stats[$];
	int       errors;

	running_mean_stddev dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("running_mean_stddev verification failed");
		$finish;
	end

	function automatic logic [63:0] isqrt(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic void welford_add(ref welford_t a, input logic [63:0] xq);
		logic [63:0] k, m, mag, q, prod;
		logic [127:0] wide;
		bit up;
		if (a.empty) begin
			a.empty = 0;
			a.avg = xq;
			a.sumsq = 0;
			a.num = 1;
			return;
		end
		if (a.num < COUNT_MAX)
			a.num++;
		k = (a.num != 0) ? a.num : 1;
		m = a.avg & 64'hFFFF_FFFF;
		up = xq >= m;
		mag = up ? xq - m : m - xq;
		q = mag / k;
		a.avg = (up ? m + q : m - q) & 64'hFFFF_FFFF;
		wide = mag * (mag - q);
		prod = (wide[127:64] != 0) ? '1 : wide[63:0];
		a.sumsq = (a.sumsq > ~prod) ? '1 : a.sumsq + prod;
	endfunction

	function automatic logic [31:0] sample_sd(welford_t a);
		if (a.num <= 1)
			return 0;
		return 32'(isqrt(a.sumsq / (a.num - 1)));
	endfunction

	function automatic stats_t predict_stats(logic [15:0] x, bit nreg, bit ntot);
		stats_t s;
		logic [63:0] xq;
		xq = {32'd0, x, 16'd0};
		if (ntot)
			total_acc = '{0, 0, 0, 1};
		if (nreg)
			region_acc = '{0, 0, 0, 1};
		welford_add(total_acc, xq);
		welford_add(region_acc, xq);
		s.region_mean = region_acc.avg[31:0];
		s.region_sd = sample_sd(region_acc);
		s.region_count = region_acc.num[23:0];
		s.total_mean = total_acc.avg[31:0];
		s.total_sd = sample_sd(total_acc);
		s.total_count = total_acc.num[23:0];
		return s;
	endfunction

	task automatic send_sample(logic [15:0] x, bit nreg, bit ntot);
		repeat ($urandom_range(0, 3)) @(posedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= x;
		s_tuser <= {ntot, nreg};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		expected_stats.push_back(predict_stats(x, nreg, ntot));
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (expected_stats.size() != 0)
			@(posedge clk);
	endtask

	// Receiver: a random gap before each result, each result compared whole with the next expected one.
	initial begin
		stats_t got, want;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			int gap;
			gap = $urandom_range(0, 3);
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do
				@(posedge clk);
			while (!(m_tvalid && m_tready));
			got = m_tdata;
			if (expected_stats.size() == 0) begin
				$display("%0t: unexpected result %h", $time, m_tdata);
				errors++;
			end else begin
				want = expected_stats.pop_front();
				if (got !== want) begin
					$display("%0t: mismatch expected %h actual %h", $time, want, got);
					errors++;
				end
			end
		end
	end

	task automatic test_directed();
		send_sample(16'd0, 1, 1);
		send_sample(16'hFFFF, 0, 0);
		send_sample(16'd0, 0, 0);
		send_sample(16'hFFFF, 0, 0);
		send_sample(16'h5555, 1, 0);
		send_sample(16'hAAAA, 0, 1);
		send_sample(16'h1234, 1, 1);
		send_sample(16'h1234, 0, 0);
		send_sample(16'h0001, 0, 0);
		wait_drained();
		for (int i = 0; i < 12; i++)
			send_sample(i[0] ? 16'hFFFF : 16'h0000, 0, 0);
	endtask

	task automatic test_random_regions();
		int n;
		n = 0;
		while (n < 1200) begin
			int len;
			logic [15:0] base, spread;
			len = $urandom_range(1, 40);
			base = 16'($urandom);
			spread = 16'hFFFF >> $urandom_range(0, 15);
			for (int i = 0; i < len && n < 1200; i++) begin
				send_sample(base ^ (spread & 16'($urandom)), i == 0,
					(i == 0) && ($urandom_range(0, 7) == 0));
				n++;
			end
			if (n % 200 < len)
				wait_drained();
		end
	endtask

	initial begin
		errors = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		region_acc = '{0, 0, 0, 1};
		total_acc = '{0, 0, 0, 1};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_regions();
		wait_drained();
		repeat (400) @(posedge clk);
		if (errors == 0 && expected_stats.size() == 0)
			$display("running_mean_stddev verification clean");
		else
			$display("running_mean_stddev verification failed");
		$finish;
	end
endmodule
